// File: rtl/core/serial_frame_deframer_unit_assert.svh
// Assertion macros used by the deframer RTL.
`ifndef SERIAL_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Check an implication on every rising edge outside reset.
`define SFD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("deframer assertion failed");
// Check that a condition never holds outside reset.
`define SFD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("deframer forbidden condition seen");
`else
`define SFD_ASSERT(lbl, clk, rst_n, prop)
`define SFD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/sfd_pkg.sv
// Constants, types and command decode for the serial frame deframer.
package sfd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam int unsigned PayloadMax = 5;
  localparam int unsigned EndLen     = 4;

  localparam logic [7:0] END_MARKER [EndLen] = '{8'hCC, 8'h33, 8'hC3, 8'h3C};

  // Result status codes
  localparam logic FRAME_DONE  = 1'b0;
  localparam logic FRAME_ABORT = 1'b1;

  typedef struct packed {
    logic       known;
    logic [2:0] len;
  } cmd_info_t;

  // Map a command byte to its payload length.
  function automatic cmd_info_t cmd_decode(input logic [7:0] cmd);
    cmd_info_t info;
    info.known = 1'b1;
    info.len   = 3'd0;
    case (cmd)
      8'h00: info.len = 3'd3;
      8'h02, 8'h07, 8'h14: info.len = 3'd2;
      8'h08: info.len = 3'd5;
      8'h01, 8'h03, 8'h04, 8'h05, 8'h09, 8'h0A, 8'h12, 8'h13: info.len = 3'd1;
      default: info.known = 1'b0;
    endcase
    return info;
  endfunction

endpackage

// File: rtl/core/serial_frame_deframer_unit.sv
// Serial frame deframer: byte-wide parser with a registered result stage.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o  | rx_byte_i
//  out     | output    | out_valid_o / out_stall_i| frame_status_o .. checksum_ok_o
//
// One byte per cycle while the input is not stalled: the parser state steps once for each accepted item and
// a finished frame lands in the result register in the cycle after its checksum is accepted.
// The input stalls only while a held result is itself stalled at the output.
// Asynchronous active-low reset puts the parser in sync hunting with no
// result pending.
`include "serial_frame_deframer_unit_assert.svh"
module serial_frame_deframer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       frame_status_o,
  output logic [7:0] sender_id_o,
  output logic [7:0] command_code_o,
  output logic [2:0] payload_len_o,
  output logic [7:0] payload_b0_o,
  output logic [7:0] payload_b1_o,
  output logic [7:0] payload_b2_o,
  output logic [7:0] payload_b3_o,
  output logic [7:0] payload_b4_o,
  output logic       end_marker_ok_o,
  output logic       checksum_ok_o
);
  import sfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_SENDER  = 3'd2,
    PH_CMD     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_END     = 3'd5,
    PH_CHECK   = 3'd6
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] sender_q, sender_d;
  logic [7:0] command_q, command_d;
  logic [7:0] pl_q [PayloadMax];
  logic [7:0] pl_d [PayloadMax];
  logic [2:0] idx_q, idx_d;
  logic [2:0] exp_len_q, exp_len_d;
  logic       end_ok_q, end_ok_d;

  logic       out_valid_q;
  logic       status_q, status_d;
  logic [7:0] res_sender_q, res_command_q;
  logic [2:0] res_len_q, res_len_d;
  logic [7:0] res_pl_q [PayloadMax];
  logic [7:0] res_pl_d [PayloadMax];
  logic       res_end_ok_q, res_end_ok_d;
  logic       res_chk_ok_q, res_chk_ok_d;

  logic       accept;
  logic       emit;
  logic [2:0] idx_inc;
  cmd_info_t  info;

  // Stall input only while a held result cannot leave
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign idx_inc    = idx_q + 3'd1;
  assign info       = cmd_decode(rx_byte_i);

  // Parser step for one accepted item
  always_comb begin
    phase_d      = phase_q;
    xor_d        = xor_q;
    sender_d     = sender_q;
    command_d    = command_q;
    pl_d         = pl_q;
    idx_d        = idx_q;
    exp_len_d    = exp_len_q;
    end_ok_d     = end_ok_q;
    emit         = 1'b0;
    status_d     = FRAME_DONE;
    res_len_d    = 3'd0;
    res_end_ok_d = 1'b0;
    res_chk_ok_d = 1'b0;
    for (int i = 0; i < PayloadMax; i++) begin
      res_pl_d[i] = 8'h00;
    end
    case (phase_q)
      PH_HUNT2: begin
        if (rx_byte_i == SYNC_SECOND) begin
          xor_d   = SYNC_FIRST ^ SYNC_SECOND;
          phase_d = PH_SENDER;
        end else begin
          phase_d = PH_HUNT1;
        end
      end
      PH_SENDER: begin
        sender_d = rx_byte_i;
        xor_d    = xor_q ^ rx_byte_i;
        phase_d  = PH_CMD;
      end
      PH_CMD: begin
        command_d = rx_byte_i;
        xor_d     = xor_q ^ rx_byte_i;
        if (!info.known) begin
          // Abort the frame with an error result
          emit     = 1'b1;
          status_d = FRAME_ABORT;
          phase_d  = PH_HUNT1;
        end else begin
          for (int i = 0; i < PayloadMax; i++) begin
            pl_d[i] = 8'h00;
          end
          exp_len_d = info.len;
          idx_d     = 3'd0;
          end_ok_d  = 1'b1;
          phase_d   = (info.len == 3'd0) ? PH_END : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        for (int i = 0; i < PayloadMax; i++) begin
          if (idx_q == 3'(i)) begin
            pl_d[i] = rx_byte_i;
          end
        end
        xor_d = xor_q ^ rx_byte_i;
        idx_d = idx_inc;
        if (idx_inc >= exp_len_q) begin
          idx_d   = 3'd0;
          phase_d = PH_END;
        end
      end
      PH_END: begin
        if (rx_byte_i != END_MARKER[idx_q[1:0]]) begin
          end_ok_d = 1'b0;
        end
        xor_d = xor_q ^ rx_byte_i;
        idx_d = idx_inc;
        if (idx_inc >= 3'(EndLen)) begin
          idx_d   = 3'd0;
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        emit         = 1'b1;
        res_len_d    = exp_len_q;
        res_end_ok_d = end_ok_q;
        res_chk_ok_d = (rx_byte_i == xor_q);
        for (int i = 0; i < PayloadMax; i++) begin
          res_pl_d[i] = (3'(i) < exp_len_q) ? pl_q[i] : 8'h00;
        end
        phase_d = PH_HUNT1;
      end
      default: begin
        phase_d = (rx_byte_i == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  // Hold parser state; advance on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT1;
      xor_q     <= 8'h00;
      sender_q  <= 8'h00;
      command_q <= 8'h00;
      idx_q     <= 3'd0;
      exp_len_q <= 3'd0;
      end_ok_q  <= 1'b1;
    end else if (accept) begin
      phase_q   <= phase_d;
      xor_q     <= xor_d;
      sender_q  <= sender_d;
      command_q <= command_d;
      idx_q     <= idx_d;
      exp_len_q <= exp_len_d;
      end_ok_q  <= end_ok_d;
    end
  end

  // Payload store
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pl_q <= pl_d;
    end
  end

  // Result valid: set on emit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      status_q      <= status_d;
      res_sender_q  <= sender_d;
      res_command_q <= command_d;
      res_len_q     <= res_len_d;
      res_pl_q      <= res_pl_d;
      res_end_ok_q  <= res_end_ok_d;
      res_chk_ok_q  <= res_chk_ok_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_status_o  = status_q;
  assign sender_id_o     = res_sender_q;
  assign command_code_o  = res_command_q;
  assign payload_len_o   = res_len_q;
  assign payload_b0_o    = res_pl_q[0];
  assign payload_b1_o    = res_pl_q[1];
  assign payload_b2_o    = res_pl_q[2];
  assign payload_b3_o    = res_pl_q[3];
  assign payload_b4_o    = res_pl_q[4];
  assign end_marker_ok_o = res_end_ok_q;
  assign checksum_ok_o   = res_chk_ok_q;

  `SFD_ASSERT(a_check_emits, clk_i, rst_ni, (accept && phase_q == PH_CHECK) |=> out_valid_q)
  `SFD_ASSERT(a_abort_clean, clk_i, rst_ni, (out_valid_q && status_q == FRAME_ABORT) |-> (res_len_q == 3'd0 && !res_end_ok_q && !res_chk_ok_q))
  `SFD_ASSERT(a_len_range, clk_i, rst_ni, out_valid_q |-> (res_len_q <= 3'(PayloadMax)))
  `SFD_ASSERT_NEVER(a_end_idx, clk_i, rst_ni, phase_q == PH_END && idx_q >= 3'(EndLen))

endmodule

// File: dv/tb_serial_frame_deframer_unit.sv
// Self-checking testbench for the serial frame deframer with a built-in frame predictor.
module tb_serial_frame_deframer_unit;
  import sfd_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RX_ITEMS    = 1150;
  localparam int IDLE_PCT    = 32;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 8;
  localparam int NUM_CMDS    = 13;

  // Command table: codes and their payload lengths
  localparam logic [7:0] KNOWN_CMDS [NUM_CMDS] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04,
    8'h05, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h12, 8'h13, 8'h14};
  localparam int KNOWN_LENS [NUM_CMDS] = '{3, 1, 2, 1, 1, 1, 2, 5, 1, 1, 1, 1, 2};
  localparam logic [7:0] CMD_UNUSED    = 8'h06;
  localparam logic [7:0] CMD_FIVE_BYTE = 8'h08;

  typedef enum logic [2:0] {
    SEEK_SYNC1, SEEK_SYNC2, TAKE_SENDER, TAKE_COMMAND, TAKE_PAYLOAD, TAKE_END, TAKE_CHECKSUM
  } rx_phase_e;

  typedef struct packed {
    logic            status;
    logic [7:0]      sender;
    logic [7:0]      command;
    logic [2:0]      len;
    logic [0:4][7:0] payload;
    logic            end_ok;
    logic            chk_ok;
  } frame_result_t;

  typedef struct {
    logic [7:0]    rx;
    bit            typed;
    frame_result_t res;
  } stim_row_t;

  localparam frame_result_t NO_FRAME = '0;

  // DUT signals
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       frame_status_o;
  logic [7:0] sender_id_o;
  logic [7:0] command_code_o;
  logic [2:0] payload_len_o;
  logic [7:0] payload_b0_o, payload_b1_o, payload_b2_o, payload_b3_o, payload_b4_o;
  logic       end_marker_ok_o;
  logic       checksum_ok_o;

  // Predictor state
  rx_phase_e       rx_phase      = SEEK_SYNC1;
  logic [7:0]      xor_acc       = 8'h00;
  logic [7:0]      frame_sender  = 8'h00;
  logic [7:0]      frame_command = 8'h00;
  logic [0:4][7:0] frame_payload = '0;
  logic [2:0]      rx_index      = 3'd0;
  logic [2:0]      frame_len     = 3'd0;
  logic            marker_good   = 1'b1;

  frame_result_t pending_frames[$];
  stim_row_t     directed_rows[$];
  int            mismatches = 0;
  bit            quiet      = 1'b0;
  bit            hold_start = 1'b0;
  int            hold_left  = 0;
  frame_result_t seen_frame;
  frame_result_t want_frame;

  serial_frame_deframer_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_status_o  (frame_status_o),
    .sender_id_o     (sender_id_o),
    .command_code_o  (command_code_o),
    .payload_len_o   (payload_len_o),
    .payload_b0_o    (payload_b0_o),
    .payload_b1_o    (payload_b1_o),
    .payload_b2_o    (payload_b2_o),
    .payload_b3_o    (payload_b3_o),
    .payload_b4_o    (payload_b4_o),
    .end_marker_ok_o (end_marker_ok_o),
    .checksum_ok_o   (checksum_ok_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Look up the payload length of a command, -1 when unknown
  function automatic int cmd_payload_len(input logic [7:0] cmd);
    int len;
    len = -1;
    for (int k = 0; k < NUM_CMDS; k++)
      if (KNOWN_CMDS[k] == cmd) len = KNOWN_LENS[k];
    return len;
  endfunction

  // Advance the frame parser by one byte and report a finished frame
  task automatic parse_rx_byte(input logic [7:0] b, output bit got, output frame_result_t f);
    int len;
    got = 1'b0;
    f   = NO_FRAME;
    case (rx_phase)
      SEEK_SYNC2: begin
        if (b == SYNC_SECOND) begin
          xor_acc  = SYNC_FIRST ^ SYNC_SECOND;
          rx_phase = TAKE_SENDER;
        end else begin
          // drop the byte, never reuse it as a first sync byte
          rx_phase = SEEK_SYNC1;
        end
      end
      TAKE_SENDER: begin
        frame_sender = b;
        xor_acc ^= b;
        rx_phase = TAKE_COMMAND;
      end
      TAKE_COMMAND: begin
        frame_command = b;
        xor_acc ^= b;
        len = cmd_payload_len(b);
        if (len < 0) begin
          // abort on an unknown command and hunt again
          got = 1'b1;
          f.status  = FRAME_ABORT;
          f.sender  = frame_sender;
          f.command = b;
          rx_phase  = SEEK_SYNC1;
        end else begin
          frame_payload = '0;
          frame_len     = 3'(len);
          rx_index      = 3'd0;
          marker_good   = 1'b1;
          rx_phase      = (len == 0) ? TAKE_END : TAKE_PAYLOAD;
        end
      end
      TAKE_PAYLOAD: begin
        if (rx_index < 3'd5) frame_payload[rx_index] = b;
        xor_acc ^= b;
        rx_index = rx_index + 3'd1;
        if (rx_index >= frame_len) begin
          rx_index = 3'd0;
          rx_phase = TAKE_END;
        end
      end
      TAKE_END: begin
        if (b != END_MARKER[rx_index[1:0]]) marker_good = 1'b0;
        xor_acc ^= b;
        rx_index = rx_index + 3'd1;
        if (rx_index >= 3'd4) begin
          rx_index = 3'd0;
          rx_phase = TAKE_CHECKSUM;
        end
      end
      TAKE_CHECKSUM: begin
        // payload store was cleared at the command, so unused bytes are zero
        got = 1'b1;
        f.status  = FRAME_DONE;
        f.sender  = frame_sender;
        f.command = frame_command;
        f.len     = frame_len;
        f.payload = frame_payload;
        f.end_ok  = marker_good;
        f.chk_ok  = (b == xor_acc);
        rx_phase  = SEEK_SYNC1;
      end
      default: begin
        rx_phase = (b == SYNC_FIRST) ? SEEK_SYNC2 : SEEK_SYNC1;
      end
    endcase
  endtask

  // Offer one item after a random gap, then predict once it is taken
  task automatic push_rx_byte(input logic [7:0] b, input bit typed, input frame_result_t res);
    bit            got;
    frame_result_t f;
    while (!quiet && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_rx_byte(b, got, f);
    if (typed) pending_frames.push_back(res);
    else if (got) pending_frames.push_back(f);
  endtask

  // Compare one field and report the first few mismatches
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] seen);
    if (want !== seen) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch on %s: expected %02h, got %02h", name, want, seen);
    end
  endtask

  // Drive the output stall: random, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left  = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Check each accepted result against the oldest expected frame
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_frame = '{frame_status_o, sender_id_o, command_code_o, payload_len_o,
                     '{payload_b0_o, payload_b1_o, payload_b2_o, payload_b3_o, payload_b4_o},
                     end_marker_ok_o, checksum_ok_o};
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: status %0b sender %02h command %02h",
                   frame_status_o, sender_id_o, command_code_o);
      end else begin
        want_frame = pending_frames.pop_front();
        check_field("frame_status", 8'(want_frame.status), 8'(seen_frame.status));
        check_field("sender_id", want_frame.sender, seen_frame.sender);
        check_field("command_code", want_frame.command, seen_frame.command);
        check_field("payload_len", 8'(want_frame.len), 8'(seen_frame.len));
        for (int k = 0; k < PayloadMax; k++)
          check_field($sformatf("payload_b%0d", k), want_frame.payload[k],
                      seen_frame.payload[k]);
        check_field("end_marker_ok", 8'(want_frame.end_ok), 8'(seen_frame.end_ok));
        check_field("checksum_ok", 8'(want_frame.chk_ok), 8'(seen_frame.chk_ok));
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [7:0] seq[$];
    logic [7:0] chk;
    logic [7:0] cmd;
    int         items_sent;
    int         seq_count;
    int         kind;
    int         pick;
    int         wait_cycles;
    bit         counted;

    items_sent = 0;
    seq_count  = 0;

    // Directed: dropped bytes, broken sync, unknown command, a frame at the extremes
    directed_rows.push_back(stim_row_t'{8'h00, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{SYNC_FIRST, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{8'h00, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{SYNC_FIRST, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{SYNC_SECOND, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{8'hFF, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{CMD_UNUSED, 1'b1,
      frame_result_t'{FRAME_ABORT, 8'hFF, CMD_UNUSED, 3'd0, '0, 1'b0, 1'b0}});
    directed_rows.push_back(stim_row_t'{SYNC_FIRST, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{SYNC_FIRST, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{SYNC_SECOND, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{SYNC_FIRST, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{SYNC_SECOND, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{8'h00, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{CMD_FIVE_BYTE, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{8'hFF, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{8'h00, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{8'hFF, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{8'h00, 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{8'hFF, 1'b0, NO_FRAME});
    for (int k = 0; k < EndLen; k++)
      directed_rows.push_back(stim_row_t'{END_MARKER[k], 1'b0, NO_FRAME});
    directed_rows.push_back(stim_row_t'{8'h08, 1'b1,
      frame_result_t'{FRAME_DONE, 8'h00, CMD_FIVE_BYTE, 3'd5,
                      '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b1, 1'b1}});

    // Hold reset, then release
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r])
      push_rx_byte(directed_rows[r].rx, directed_rows[r].typed, directed_rows[r].res);

    // Random: mostly well-formed frames, some aborts, broken sync and noise
    while (items_sent < RX_ITEMS) begin
      seq.delete();
      counted = 1'b1;
      kind    = $urandom_range(0, 99);
      if (kind < 72) begin
        pick = $urandom_range(0, NUM_CMDS - 1);
        seq.push_back(SYNC_FIRST);
        seq.push_back(SYNC_SECOND);
        seq.push_back(8'($urandom));
        seq.push_back(KNOWN_CMDS[pick]);
        for (int k = 0; k < KNOWN_LENS[pick]; k++)
          seq.push_back(($urandom_range(0, 9) == 0) ?
                        ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom));
        for (int k = 0; k < EndLen; k++) seq.push_back(END_MARKER[k]);
        // corrupt one end-marker byte now and then
        if ($urandom_range(0, 99) < 12)
          seq[4 + KNOWN_LENS[pick] + $urandom_range(0, EndLen - 1)] = 8'($urandom);
        chk = 8'h00;
        foreach (seq[k]) chk ^= seq[k];
        if ($urandom_range(0, 99) < 15) chk ^= 8'($urandom_range(1, 255));
        seq.push_back(chk);
      end else if (kind < 82) begin
        cmd = 8'($urandom);
        while (cmd_payload_len(cmd) >= 0) cmd = 8'($urandom);
        seq.push_back(SYNC_FIRST);
        seq.push_back(SYNC_SECOND);
        seq.push_back(8'($urandom));
        seq.push_back(cmd);
      end else if (kind < 91) begin
        cmd = 8'($urandom);
        while (cmd == SYNC_SECOND) cmd = 8'($urandom);
        seq.push_back(SYNC_FIRST);
        seq.push_back(cmd);
      end else begin
        counted = 1'b0;
        repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom));
      end

      foreach (seq[k]) push_rx_byte(seq[k], 1'b0, NO_FRAME);
      if (counted) items_sent += seq.size();
      seq_count++;

      // Long receiver hold-off while items keep coming
      if (seq_count == 20) hold_start = 1'b1;
      // Sender pause until every expected frame is out
      if (seq_count == 45) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_frames.size() != 0);
      end
      // Stretch without idling on either side
      quiet = (seq_count >= 55) && (seq_count < 75);
    end
    in_valid_i <= 1'b0;
    quiet = 1'b0;

    // Drain outstanding frames, then let a few more cycles pass
    wait_cycles = 0;
    while (pending_frames.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    if (pending_frames.size() != 0) begin
      mismatches += pending_frames.size();
      $display("%0d expected frames never arrived", pending_frames.size());
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb_serial_frame_deframer_unit: PASS");
    end else begin
      $display("tb_serial_frame_deframer_unit: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * 200000);
    $display("tb_serial_frame_deframer_unit: FAIL");
    $finish;
  end

endmodule
